>>> sv/tsbd_pkg.sv
// Shared types, constants and the per-byte decode function for the text stream decoder.
// Used by tsbd_queue, tsbd_front, tsbd_back, the top level and the checker; no dependencies.
package tsbd_pkg;

	localparam int LINE_COUNT_BITS_DEF = 32;
	localparam int QUEUE_DEPTH         = 2;

	typedef enum logic [1:0] {
		ENC_U8     = 2'd0,
		ENC_U16LE  = 2'd1,
		ENC_U16BE  = 2'd2,
		ENC_LATIN1 = 2'd3
	} enc_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_BAD_CONT = 2'd1,
		ERR_RANGE    = 2'd2,
		ERR_TRUNC    = 2'd3
	} err_t;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_HELD1  = 2'd1,
		PH_HELD2  = 2'd2,
		PH_DECODE = 2'd3
	} phase_t;

	typedef enum logic {
		REG_DEFAULT_ENC = 1'b0,
		REG_FIRST_LINE  = 1'b1
	} reg_idx_t;

	localparam logic [7:0]  BOM_FE = 8'hFE;
	localparam logic [7:0]  BOM_FF = 8'hFF;
	localparam logic [7:0]  BOM_EF = 8'hEF;
	localparam logic [7:0]  BOM_BB = 8'hBB;
	localparam logic [7:0]  BOM_BF = 8'hBF;
	localparam logic [20:0] CP_LF  = 21'h00000A;
	localparam logic [20:0] CP_CR  = 21'h00000D;
	localparam logic [20:0] CP_MAX = 21'h10FFFF;

	// Running decode state between bytes of one stream
	typedef struct packed {
		logic [14:0] partial;
		logic        bad;
		logic [1:0]  left;
		logic        low_vld;
		logic [7:0]  low_byte;
		logic        after_cr;
	} dec_state_t;

	typedef struct packed {
		logic        vld;
		logic [20:0] cp;
		err_t        err;
		logic        bump;
	} dec_res_t;

	typedef struct packed {
		dec_state_t st;
		dec_res_t   res;
	} dec_step_t;

	typedef struct packed {
		logic [20:0] cp;
		err_t        err;
		logic        bump;
	} slot_t;

	// All results of one input byte, packed from slot 0 up to slot last
	typedef struct packed {
		slot_t [3:0] slot;
		logic [1:0]  last;
		enc_t        enc;
		logic        mark;
	} bundle_t;

	// Decode one byte in the given encoding; at most one result
	function automatic dec_step_t dec_byte(dec_state_t s, enc_t enc, logic [7:0] b);
		dec_step_t   r;
		logic [20:0] v;
		logic        bad;
		logic        pc_en;
		logic [20:0] pc;
		logic [15:0] unit;
		r = '0;
		r.st = s;
		pc_en = 1'b0;
		pc = '0;
		v = {s.partial, b[5:0]};
		bad = s.bad || (b[7:6] != 2'b10);
		unit = (enc == ENC_U16LE) ? {b, s.low_byte} : {s.low_byte, b};
		unique case (enc)
			ENC_U8: begin
				if (s.left == 2'd0) begin
					priority if (!b[7]) begin
						pc_en = 1'b1;
						pc = {13'd0, b};
					end else if (b[7:5] == 3'b110) begin
						r.st.partial = {10'd0, b[4:0]};
						r.st.bad = 1'b0;
						r.st.left = 2'd1;
					end else if (b[7:4] == 4'b1110) begin
						r.st.partial = {11'd0, b[3:0]};
						r.st.bad = 1'b0;
						r.st.left = 2'd2;
					end else if (b[7:3] == 5'b11110) begin
						r.st.partial = {12'd0, b[2:0]};
						r.st.bad = 1'b0;
						r.st.left = 2'd3;
					end else begin
						// stray continuation or invalid lead byte passes through as its own code point
						pc_en = 1'b1;
						pc = {13'd0, b};
					end
				end else begin
					r.st.left = s.left - 2'd1;
					if (s.left == 2'd1) begin
						r.st.partial = '0;
						r.st.bad = 1'b0;
						if (bad) begin
							r.st.after_cr = 1'b0;
							r.res = '{vld: 1'b1, cp: '0, err: ERR_BAD_CONT, bump: 1'b0};
						end else if (v > CP_MAX) begin
							r.st.after_cr = 1'b0;
							r.res = '{vld: 1'b1, cp: '0, err: ERR_RANGE, bump: 1'b0};
						end else begin
							pc_en = 1'b1;
							pc = v;
						end
					end else begin
						r.st.partial = v[14:0];
						r.st.bad = bad;
					end
				end
			end
			ENC_U16LE, ENC_U16BE: begin
				if (s.low_vld) begin
					r.st.low_vld = 1'b0;
					r.st.low_byte = '0;
					pc_en = 1'b1;
					pc = {5'd0, unit};
				end else begin
					r.st.low_vld = 1'b1;
					r.st.low_byte = b;
				end
			end
			ENC_LATIN1: begin
				pc_en = 1'b1;
				pc = {13'd0, b};
			end
		endcase
		if (pc_en) begin
			if (r.st.after_cr && pc == CP_LF) begin
				// drop the LF of a CRLF pair
				r.st.after_cr = 1'b0;
			end else begin
				r.st.after_cr = 1'b0;
				r.res.vld = 1'b1;
				r.res.err = ERR_NONE;
				if (pc == CP_CR) begin
					r.res.cp = CP_LF;
					r.res.bump = 1'b1;
					r.st.after_cr = 1'b1;
				end else begin
					r.res.cp = pc;
					r.res.bump = (pc == CP_LF);
				end
			end
		end
		return r;
	endfunction

endpackage

>>> sv/tsbd_queue.sv
// Short FIFO between the front (classify) and back (deliver) halves.
// Generic width; depth defaults from tsbd_pkg.
module tsbd_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = tsbd_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             full,
	output logic             not_empty,
	output logic [WIDTH-1:0] rdata
);
	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]    mem_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] cnt_q;

	function automatic logic [PTR_BITS-1:0] next_ptr(logic [PTR_BITS-1:0] p);
		return (p == PTR_BITS'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full      = (cnt_q == CNT_BITS'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign rdata     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> sv/tsbd_front.sv
// Front half: accepts bytes, detects the byte order mark and decodes into a result bundle.
// Holds configuration registers; depends on tsbd_pkg.
module tsbd_front #(
	parameter int LINE_COUNT_BITS = tsbd_pkg::LINE_COUNT_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [1:0]                 cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [7:0]                 data_byte,
	input  logic                       stream_end,
	input  logic                       q_full,
	output logic                       push,
	output tsbd_pkg::bundle_t          push_bundle,
	output logic [LINE_COUNT_BITS-1:0] push_base
);
	import tsbd_pkg::*;

	localparam int SUM_BITS = LINE_COUNT_BITS + 2;

	phase_t                     phase_q, phase_d;
	logic [7:0]                 held0_q, held0_d;
	logic [7:0]                 held1_q, held1_d;
	enc_t                       enc_q, enc_d;
	logic                       mark_q, mark_d;
	dec_state_t                 dst_q, dst_d;
	logic [LINE_COUNT_BITS-1:0] line_q, line_d;
	enc_t                       def_enc_q;
	logic                       first_line_q;

	logic [7:0]                 rb0, rb1, rb2;
	logic [2:0]                 rv;
	dec_state_t                 s0, s1, s2, s3;
	dec_step_t                  st0, st1, st2;
	dec_res_t                   cand [4];
	logic [2:0]                 n_res;
	logic [2:0]                 n_bump;
	logic [SUM_BITS-1:0]        lsum;
	logic                       acc;

	assign in_ready = !q_full;
	assign acc      = in_valid && in_ready;

	// Next state of mark detection and the list of bytes to decode
	always_comb begin
		phase_d = phase_q;
		held0_d = held0_q;
		held1_d = held1_q;
		enc_d   = enc_q;
		mark_d  = mark_q;
		rb0     = data_byte;
		rb1     = data_byte;
		rb2     = data_byte;
		rv      = 3'b000;
		unique case (phase_q)
			PH_IDLE: begin
				mark_d = 1'b0;
				if ((data_byte == BOM_FE || data_byte == BOM_FF || data_byte == BOM_EF)
						&& !stream_end) begin
					held0_d = data_byte;
					phase_d = PH_HELD1;
				end else begin
					enc_d   = def_enc_q;
					phase_d = PH_DECODE;
					rv      = 3'b001;
				end
			end
			PH_HELD1: begin
				priority if (held0_q == BOM_FE && data_byte == BOM_FF) begin
					enc_d   = ENC_U16BE;
					mark_d  = 1'b1;
					phase_d = PH_DECODE;
				end else if (held0_q == BOM_FF && data_byte == BOM_FE) begin
					enc_d   = ENC_U16LE;
					mark_d  = 1'b1;
					phase_d = PH_DECODE;
				end else if (held0_q == BOM_EF && !stream_end) begin
					held1_d = data_byte;
					phase_d = PH_HELD2;
				end else begin
					enc_d   = def_enc_q;
					phase_d = PH_DECODE;
					rb0     = held0_q;
					rv      = 3'b011;
				end
			end
			PH_HELD2: begin
				if (held1_q == BOM_BB && data_byte == BOM_BF) begin
					enc_d   = ENC_U8;
					mark_d  = 1'b1;
					phase_d = PH_DECODE;
				end else begin
					enc_d   = def_enc_q;
					phase_d = PH_DECODE;
					rb0     = held0_q;
					rb1     = held1_q;
					rv      = 3'b111;
				end
			end
			PH_DECODE: begin
				rv = 3'b001;
			end
		endcase
		if (stream_end) begin
			phase_d = PH_IDLE;
		end
	end

	// Decode chain, result packing and line count update
	always_comb begin
		s0   = (phase_q == PH_IDLE) ? '0 : dst_q;
		st0  = dec_byte(s0, enc_d, rb0);
		s1   = rv[0] ? st0.st : s0;
		st1  = dec_byte(s1, enc_d, rb1);
		s2   = rv[1] ? st1.st : s1;
		st2  = dec_byte(s2, enc_d, rb2);
		s3   = rv[2] ? st2.st : s2;

		cand[0] = rv[0] ? st0.res : '0;
		cand[1] = rv[1] ? st1.res : '0;
		cand[2] = rv[2] ? st2.res : '0;
		cand[3] = '0;
		if (stream_end && (s3.left != 2'd0 || s3.low_vld)) begin
			cand[3] = '{vld: 1'b1, cp: '0, err: ERR_TRUNC, bump: 1'b0};
		end
		dst_d = stream_end ? '0 : s3;

		push_bundle = '0;
		n_res  = '0;
		n_bump = '0;
		for (int k = 0; k < 4; k++) begin
			if (cand[k].vld) begin
				push_bundle.slot[n_res[1:0]] = '{cp: cand[k].cp, err: cand[k].err,
					bump: cand[k].bump};
				n_res  = n_res + 3'd1;
				n_bump = n_bump + {2'd0, cand[k].bump};
			end
		end
		push_bundle.last = 2'(n_res - 3'd1);
		push_bundle.enc  = enc_d;
		push_bundle.mark = mark_d;

		push_base = (phase_q == PH_IDLE) ? LINE_COUNT_BITS'(first_line_q) : line_q;
		lsum      = {2'b00, push_base} + SUM_BITS'(n_bump);
		line_d    = (|lsum[SUM_BITS-1:LINE_COUNT_BITS]) ? '1 : lsum[LINE_COUNT_BITS-1:0];

		push = acc && (n_res != 3'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			enc_q        <= ENC_U8;
			mark_q       <= 1'b0;
			dst_q        <= '0;
			line_q       <= LINE_COUNT_BITS'(1);
			def_enc_q    <= ENC_U8;
			first_line_q <= 1'b1;
		end else begin
			if (acc) begin
				phase_q <= phase_d;
				enc_q   <= enc_d;
				mark_q  <= mark_d;
				dst_q   <= dst_d;
				line_q  <= line_d;
			end
			if (cfg_we && cfg_index == REG_DEFAULT_ENC) begin
				def_enc_q <= enc_t'(cfg_data);
			end
			if (cfg_we && cfg_index == REG_FIRST_LINE) begin
				first_line_q <= cfg_data[0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			held0_q <= held0_d;
			held1_q <= held1_d;
		end
	end

endmodule

>>> sv/tsbd_back.sv
// Back half: walks the queued result bundle into the output register, one result per cycle unless stalled.
// Works out each result's line number; depends on tsbd_pkg.
module tsbd_back #(
	parameter int LINE_COUNT_BITS = tsbd_pkg::LINE_COUNT_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_vld,
	input  tsbd_pkg::bundle_t          head,
	input  logic [LINE_COUNT_BITS-1:0] head_base,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [20:0]                code_point,
	output logic [31:0]                line_number,
	output logic [1:0]                 error_code,
	output logic [1:0]                 active_encoding,
	output logic                       bom_seen,
	output logic                       run_last
);
	import tsbd_pkg::*;

	localparam int SUM_BITS = LINE_COUNT_BITS + 2;

	logic [1:0]                 idx_q;
	logic                       out_valid_q;
	logic [20:0]                cp_q;
	logic [31:0]                line_q;
	err_t                       err_q;
	enc_t                       enc_q;
	logic                       mark_q;
	logic                       last_q;

	slot_t                      cur;
	logic [2:0]                 pre;
	logic [SUM_BITS-1:0]        lsum;
	logic [LINE_COUNT_BITS-1:0] lfull;
	logic [31:0]                line32;
	logic                       load;
	logic                       is_last;

	assign cur     = head.slot[idx_q];
	assign is_last = (idx_q == head.last);
	assign load    = q_vld && (!out_valid_q || out_ready);
	assign pop     = load && is_last;

	always_comb begin
		pre = '0;
		for (int j = 0; j < 4; j++) begin
			if (2'(j) <= idx_q) begin
				pre = pre + {2'd0, head.slot[j].bump};
			end
		end
		lsum  = {2'b00, head_base} + SUM_BITS'(pre);
		lfull = (|lsum[SUM_BITS-1:LINE_COUNT_BITS]) ? '1 : lsum[LINE_COUNT_BITS-1:0];
	end

	generate
		if (LINE_COUNT_BITS > 32) begin : g_wide
			assign line32 = (|lfull[LINE_COUNT_BITS-1:32]) ? '1 : lfull[31:0];
		end else begin : g_narrow
			assign line32 = 32'(lfull);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= is_last ? 2'd0 : idx_q + 2'd1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cp_q   <= cur.cp;
			line_q <= line32;
			err_q  <= cur.err;
			enc_q  <= head.enc;
			mark_q <= head.mark;
			last_q <= is_last;
		end
	end

	assign out_valid       = out_valid_q;
	assign code_point      = cp_q;
	assign line_number     = line_q;
	assign error_code      = err_q;
	assign active_encoding = enc_q;
	assign bom_seen        = mark_q;
	assign run_last        = last_q;

endmodule

>>> sv/text_stream_bom_decoder.sv
// The first result of an accepted byte passes through the queue and then the output register before it is shown.
// Throughput: one byte per cycle while each byte yields at most one result and the output is not
// stalled; a byte that yields n results hands them out one by one through the single output register.
// A two-entry queue between the front and back halves absorbs stalls on either side.
// Reset (arst_n, async low): stream detection restarts, line counter is one, default
// encoding UTF-8, first line number one; no clearing pass is needed.
module text_stream_bom_decoder #(
	parameter int LINE_COUNT_BITS = tsbd_pkg::LINE_COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [1:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        stream_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [20:0] code_point,
	output logic [31:0] line_number,
	output logic [1:0]  error_code,
	output logic [1:0]  active_encoding,
	output logic        bom_seen,
	output logic        run_last
);
	import tsbd_pkg::*;

	// Queue entry: line count before the byte plus its packed results
	localparam int ENTRY_BITS = LINE_COUNT_BITS + $bits(bundle_t);

	logic                       push;
	bundle_t                    push_bundle;
	logic [LINE_COUNT_BITS-1:0] push_base;
	logic                       q_full;
	logic                       q_vld;
	logic                       pop;
	logic [ENTRY_BITS-1:0]      q_head;
	bundle_t                    head;
	logic [LINE_COUNT_BITS-1:0] head_base;

	// Front: take one transaction per cycle whenever the queue has room, detect
	// the byte order mark and decode the byte into up to three results.
	tsbd_front #(
		.LINE_COUNT_BITS(LINE_COUNT_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.stream_end (stream_end),
		.q_full     (q_full),
		.push       (push),
		.push_bundle(push_bundle),
		.push_base  (push_base)
	);

	// Hold bundles between the halves; bytes with no results never enter.
	tsbd_queue #(
		.WIDTH(ENTRY_BITS),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wdata    ({push_base, push_bundle}),
		.pop      (pop),
		.full     (q_full),
		.not_empty(q_vld),
		.rdata    (q_head)
	);

	assign head      = q_head[$bits(bundle_t)-1:0];
	assign head_base = q_head[ENTRY_BITS-1:$bits(bundle_t)];

	// Back: advance through the bundle one output transaction at a time and
	// drop the entry after its last result is loaded.
	tsbd_back #(
		.LINE_COUNT_BITS(LINE_COUNT_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_vld          (q_vld),
		.head           (head),
		.head_base      (head_base),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.code_point     (code_point),
		.line_number    (line_number),
		.error_code     (error_code),
		.active_encoding(active_encoding),
		.bom_seen       (bom_seen),
		.run_last       (run_last)
	);

endmodule

>>> sv/tsbd_checker.sv
// Port-level checks on the decoder output, bound to the top level.
// Depends on tsbd_pkg and text_stream_bom_decoder.
module tsbd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [20:0] code_point,
	input logic [1:0]  error_code,
	input logic [1:0]  active_encoding,
	input logic        bom_seen,
	input logic        run_last
);
	import tsbd_pkg::*;

	// A stalled output transaction holds its contents
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid
			&& $stable({code_point, error_code, active_encoding, bom_seen, run_last}))
		else $error("output changed while stalled");

	// Error results carry a zero code point
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != ERR_NONE |-> code_point == '0)
		else $error("error result with nonzero code point");

	// Carriage returns are always turned into line feeds
	a_no_cr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> code_point != CP_CR)
		else $error("carriage return reached the output");

	// A mark only ever selects a Unicode encoding
	a_mark_enc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bom_seen |-> active_encoding != ENC_LATIN1)
		else $error("mark reported with ISO-8859-1");

	// Results of one byte follow each other without a gap
	a_run_tight: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !run_last |=> out_valid)
		else $error("gap inside the results of one byte");

endmodule

bind text_stream_bom_decoder tsbd_checker u_tsbd_checker (.*);
